FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition in this cycle implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pats_pkg.sv
package pats_pkg;

    // command codes carried in the input tuser
    localparam logic [2:0] MODE_CREATE = 3'd0;
    localparam logic [2:0] MODE_SET    = 3'd1;
    localparam logic [2:0] MODE_GET    = 3'd2;
    localparam logic [2:0] MODE_REMOVE = 3'd3;
    localparam logic [2:0] MODE_SCHED  = 3'd4;
    localparam logic [2:0] MODE_READY  = 3'd5;
    localparam logic [2:0] MODE_TICK   = 3'd6;

    localparam logic signed [7:0] PRIO_MIN  = -8'sd20;
    localparam logic signed [7:0] PRIO_MAX  = 8'sd20;
    localparam logic signed [7:0] AGE_STEP  = -8'sd1;
    localparam logic signed [7:0] DYN_FLOOR = -8'sd128;

    localparam logic [7:0] QLEN_RESET = 8'd20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_SCAN,
        S_FIX,
        S_DONE
    } t_state;

    // one table entry, static priority above dynamic priority
    typedef struct packed {
        logic signed [5:0] st;
        logic signed [7:0] dyn;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // status from the shared compare and aging unit
    typedef struct packed {
        logic              take;
        logic signed [7:0] aged;
    } t_alu_out;

    typedef struct packed {
        logic [3:0]        chosen_slot;
        logic              chosen_valid;
        logic              quantum_over;
        logic signed [5:0] static_prio;
        logic              accepted;
    } t_res;

endpackage

FILE: design/pats_ram.sv
module pats_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pats_alu.sv
module pats_alu (
    input  logic signed [7:0] i_dyn,
    input  logic signed [7:0] i_best,
    input  logic              i_first,
    output pats_pkg::t_alu_out o_res
);
    import pats_pkg::*;

    // strict compare keeps the lowest slot on ties
    always_comb begin
        o_res.take = i_first || (i_dyn < i_best);
        o_res.aged = (i_dyn == DYN_FLOOR) ? DYN_FLOOR : i_dyn + AGE_STEP;
    end

endmodule

FILE: design/priority_aging_task_scheduler.sv
// create, set, remove, tick and unused codes go from execute straight to done; get prio and
// returned ready pass through a wait state for the table read; schedule passes scan, then fix.
// one command at a time: the next transfer is taken once the result moves into the output
// register; schedule walks the table once through the shared compare and aging unit
// reset: synchronous active low, clears slot marks, running slot, tick count and
// restores quantum length to 20; the priority table is not cleared
`include "assert_macros.svh"

module priority_aging_task_scheduler #(
    parameter int NUM_TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // slot[3:0], use_current[4], priority_req[12:5], is_user[13]
    input  logic [2:0]  s_tuser,   // mode[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // chosen_slot[3:0], chosen_valid[4], quantum_over[5],
                                   // static_prio[11:6], accepted[12], system_clock[44:13]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pats_pkg::*;

    localparam int IDX_W = $clog2(NUM_TASKS);
    localparam int CNT_W = $clog2(NUM_TASKS + 1);

    // control state
    t_state                r_state, n_state;
    logic [NUM_TASKS-1:0]  r_valid, n_valid;
    logic [NUM_TASKS-1:0]  r_user, n_user;
    logic [3:0]            r_run, n_run;
    logic [7:0]            r_qleft, n_qleft;
    logic [31:0]           r_tick, n_tick;
    logic [7:0]            r_qlen, n_qlen;
    logic                  r_ovalid, n_ovalid;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_found, n_found;

    // latched command and working payload
    logic [2:0]            r_mode, n_mode;
    logic [3:0]            r_addr, n_addr;
    logic signed [7:0]     r_req, n_req;
    logic                  r_isu, n_isu;
    logic [IDX_W-1:0]      r_best, n_best;
    t_entry                r_best_ent, n_best_ent;
    t_res                  r_res, n_res;
    t_res                  r_out_res, n_out_res;
    logic [31:0]           r_out_clk, n_out_clk;

    // table port
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    t_entry                ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    t_entry                rd;

    t_alu_out              alu;

    logic [IDX_W-1:0]      a_idx;
    logic [IDX_W-1:0]      e_idx;
    logic [IDX_W-1:0]      run_idx;
    logic                  in_table;
    logic                  run_in;
    logic                  req_ok;
    logic signed [5:0]     p6;

    pats_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_TASKS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd = t_entry'(ram_rdata);

    // one compare and one saturating decrement, reused for every slot of the walk
    pats_alu u_alu (
        .i_dyn  (rd.dyn),
        .i_best (r_best_ent.dyn),
        .i_first(!r_found),
        .o_res  (alu)
    );

    assign a_idx    = IDX_W'(r_addr);
    assign e_idx    = IDX_W'(r_cnt - CNT_W'(1));
    assign run_idx  = IDX_W'(r_run);
    assign in_table = 32'(r_addr) < 32'(NUM_TASKS);
    assign run_in   = 32'(r_run) < 32'(NUM_TASKS);
    assign req_ok   = (r_req >= PRIO_MIN) && (r_req <= PRIO_MAX);
    // a rejected create still makes the task, at priority zero
    assign p6       = req_ok ? r_req[5:0] : 6'sd0;

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tdata  = {3'b000, r_out_clk, r_out_res.accepted, r_out_res.static_prio,
                       r_out_res.quantum_over, r_out_res.chosen_valid,
                       r_out_res.chosen_slot};
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {24'd0, r_qlen};

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_user     = r_user;
        n_run      = r_run;
        n_qleft    = r_qleft;
        n_tick     = r_tick;
        n_qlen     = r_qlen;
        n_cnt      = r_cnt;
        n_found    = r_found;
        n_mode     = r_mode;
        n_addr     = r_addr;
        n_req      = r_req;
        n_isu      = r_isu;
        n_best     = r_best;
        n_best_ent = r_best_ent;
        n_res      = r_res;
        n_out_res  = r_out_res;
        n_out_clk  = r_out_clk;
        // output register empties on a result transfer
        n_ovalid   = r_ovalid && !m_tready;
        ram_we     = 1'b0;
        ram_waddr  = a_idx;
        ram_wdata  = '0;
        ram_raddr  = a_idx;

        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_mode  = s_tuser;
                    n_addr  = s_tdata[4] ? r_run : s_tdata[3:0];
                    n_req   = s_tdata[12:5];
                    n_isu   = s_tdata[13];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_DONE;
                unique case (r_mode)
                    MODE_CREATE: begin
                        if (in_table) begin
                            n_valid[a_idx] = 1'b1;
                            n_user[a_idx]  = r_isu;
                            ram_we         = 1'b1;
                            ram_wdata.st   = p6;
                            ram_wdata.dyn  = {{2{p6[5]}}, p6};
                            n_res.accepted = req_ok;
                        end
                    end
                    MODE_SET: begin
                        if (in_table && r_valid[a_idx] && req_ok) begin
                            ram_we         = 1'b1;
                            ram_wdata.st   = r_req[5:0];
                            ram_wdata.dyn  = r_req;
                            n_res.accepted = 1'b1;
                        end
                    end
                    MODE_GET, MODE_READY: begin
                        n_state = S_WAIT;
                    end
                    MODE_REMOVE: begin
                        if (in_table) begin
                            n_valid[a_idx] = 1'b0;
                        end
                    end
                    MODE_SCHED: begin
                        ram_raddr = '0;
                        n_cnt     = CNT_W'(1);
                        n_found   = 1'b0;
                        n_state   = S_SCAN;
                    end
                    MODE_TICK: begin
                        n_tick = r_tick + 32'd1;
                        if (run_in && r_valid[run_idx] && r_user[run_idx]) begin
                            n_qleft            = (r_qleft == 8'd0) ? 8'd0 : r_qleft - 8'd1;
                            n_res.quantum_over = (r_qleft <= 8'd1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WAIT: begin
                // entry data for the addressed slot is on the read port now
                if (in_table && r_valid[a_idx]) begin
                    if (r_mode == MODE_GET) begin
                        n_res.static_prio = rd.st;
                    end else begin
                        ram_we        = 1'b1;
                        ram_wdata.st  = rd.st;
                        ram_wdata.dyn = {{2{rd.st[5]}}, rd.st};
                    end
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                // every valid slot is aged on the way, the winner is restored after
                ram_raddr = IDX_W'(r_cnt);
                if (r_valid[e_idx]) begin
                    ram_we        = 1'b1;
                    ram_waddr     = e_idx;
                    ram_wdata.st  = rd.st;
                    ram_wdata.dyn = alu.aged;
                    if (alu.take) begin
                        n_found    = 1'b1;
                        n_best     = e_idx;
                        n_best_ent = rd;
                    end
                end
                if (r_cnt == CNT_W'(NUM_TASKS)) begin
                    n_state = S_FIX;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_FIX: begin
                if (r_found) begin
                    ram_we             = 1'b1;
                    ram_waddr          = r_best;
                    ram_wdata          = r_best_ent;
                    n_run              = 4'(r_best);
                    n_qleft            = r_qlen;
                    n_res.chosen_slot  = 4'(r_best);
                    n_res.chosen_valid = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // wait for room in the output register
                if (!r_ovalid || m_tready) begin
                    n_out_res = r_res;
                    n_out_clk = r_tick;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // quantum length write, word aligned decode
        if (psel && penable && pwrite && !paddr[2]) begin
            n_qlen = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_user   <= '0;
            r_run    <= 4'd0;
            r_qleft  <= QLEN_RESET;
            r_tick   <= 32'd0;
            r_qlen   <= QLEN_RESET;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_user   <= n_user;
            r_run    <= n_run;
            r_qleft  <= n_qleft;
            r_tick   <= n_tick;
            r_qlen   <= n_qlen;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_addr     <= n_addr;
        r_req      <= n_req;
        r_isu      <= n_isu;
        r_best     <= n_best;
        r_best_ent <= n_best_ent;
        r_res      <= n_res;
        r_out_res  <= n_out_res;
        r_out_clk  <= n_out_clk;
    end

    // walk counter stays inside the table while scanning
    `ASSERT_CLK(a_scan_low, (r_state == S_SCAN) |-> (r_cnt != '0), "scan counter at zero")
    `ASSERT_CLK(a_scan_high, (r_state == S_SCAN) |-> (r_cnt <= CNT_W'(NUM_TASKS)), "scan past end")
    // an accepted command always starts execution next
    `ASSERT_NEXT(a_accept_exec, s_tvalid && s_tready, r_state == S_EXEC, "command not executed")
    // a picked task is a valid slot once it becomes the running slot
    `ASSERT_NEXT(a_pick_valid, (r_state == S_FIX) && r_found, r_valid[run_idx], "bad pick")
    // the clock count moves by at most one per cycle
    `ASSERT_CLK(a_tick_step, (r_tick - $past(r_tick)) <= 32'd1, "tick count jumped")

endmodule
